@@ src/fdrs_pkg.sv @@
package fdrs_pkg;

	localparam int QUEUE_DEPTH_DEF = 1024;
	localparam logic [15:0] DELAY_RESET = 16'd100;

	// Depth of the command queue between front and back, a power of two.
	localparam int CMD_DEPTH = 4;
	localparam int CMD_AW = $clog2(CMD_DEPTH);

	localparam logic [47:0] WAIT_SUM_MAX = 48'hFFFF_FFFF_FFFF;
	localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

	typedef enum logic {
		CMD_ARRIVE   = 1'b0,
		CMD_COMPLETE = 1'b1
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [31:0] now;
		logic [15:0] track;
		logic [15:0] blocks;
	} cmd_t;

	typedef struct packed {
		logic        dispatched;
		logic [31:0] start_time;
		logic [15:0] track_out;
		logic [15:0] blocks_out;
		logic [9:0]  queue_size;
		logic [9:0]  peak_queue_size;
		logic [47:0] total_wait;
		logic [31:0] peak_wait;
		logic [31:0] request_count;
		logic        queue_full;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_LAUNCH,
		ST_FETCH,
		ST_ACCUM,
		ST_RESULT
	} state_t;

endpackage

@@ src/fdrs_front.sv @@
module fdrs_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [63:0]   s_tdata,
	input  logic          s_tuser,
	output logic          cmd_valid,
	output fdrs_pkg::cmd_t cmd,
	input  logic          cmd_pop
);

	fdrs_pkg::cmd_t             q_q [fdrs_pkg::CMD_DEPTH];
	logic [fdrs_pkg::CMD_AW-1:0] wr_ptr_q;
	logic [fdrs_pkg::CMD_AW-1:0] rd_ptr_q;
	logic [fdrs_pkg::CMD_AW:0]   cnt_q;
	fdrs_pkg::cmd_t             in_cmd;
	logic                       push;
	logic                       pop;

	always_comb begin
		in_cmd.kind   = s_tuser ? fdrs_pkg::CMD_COMPLETE : fdrs_pkg::CMD_ARRIVE;
		in_cmd.now    = s_tdata[31:0];
		in_cmd.track  = s_tdata[47:32];
		in_cmd.blocks = s_tdata[63:48];
	end

	assign s_tready  = (cnt_q != (fdrs_pkg::CMD_AW+1)'(fdrs_pkg::CMD_DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = q_q[rd_ptr_q];
	assign push      = s_tvalid && s_tready;
	assign pop       = cmd_pop && cmd_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ src/fdrs_back.sv @@
module fdrs_back #(
	parameter int QUEUE_DEPTH = fdrs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [15:0]    delay,
	input  logic           cmd_valid,
	input  fdrs_pkg::cmd_t cmd,
	output logic           cmd_pop,
	output logic           res_valid,
	input  logic           res_ready,
	output fdrs_pkg::res_t res
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int QW = (AW < 10) ? AW : 10;
	localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);

	logic [63:0] mem [QUEUE_DEPTH];

	fdrs_pkg::state_t state_q;
	fdrs_pkg::state_t state_d;
	fdrs_pkg::cmd_t   cmd_q;
	fdrs_pkg::res_t   out_q;

	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [AW-1:0] occ_q;
	logic [AW-1:0] peak_q;
	logic [AW-1:0] occ_inc;
	logic          busy_q;
	logic [47:0]   wsum_q;
	logic [31:0]   wpeak_q;
	logic [31:0]   arrivals_q;
	logic          full_q;
	logic          sent_q;
	logic          out_valid_q;
	logic [31:0]   start_q;
	logic [31:0]   wait_q;
	logic [15:0]   trk_q;
	logic [15:0]   blk_q;
	logic [63:0]   rdata_q;
	logic [48:0]   sum_ext;
	logic          nonempty;

	logic do_arrive;
	logic do_launch;
	logic do_fetch;
	logic do_accum;
	logic out_load;

	assign nonempty = (occ_q != '0);
	assign occ_inc  = occ_q + 1'b1;
	assign sum_ext  = {1'b0, wsum_q} + 49'(wait_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			fdrs_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					state_d = fdrs_pkg::ST_EXEC;
				end
			end
			fdrs_pkg::ST_EXEC: begin
				if (cmd_q.kind == fdrs_pkg::CMD_COMPLETE || !busy_q) begin
					state_d = fdrs_pkg::ST_LAUNCH;
				end else begin
					state_d = fdrs_pkg::ST_RESULT;
				end
			end
			fdrs_pkg::ST_LAUNCH: begin
				state_d = nonempty ? fdrs_pkg::ST_FETCH : fdrs_pkg::ST_RESULT;
			end
			fdrs_pkg::ST_FETCH:  state_d = fdrs_pkg::ST_ACCUM;
			fdrs_pkg::ST_ACCUM:  state_d = fdrs_pkg::ST_RESULT;
			fdrs_pkg::ST_RESULT: begin
				if (!out_valid_q || res_ready) begin
					state_d = fdrs_pkg::ST_IDLE;
				end
			end
			default: state_d = fdrs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop   = 1'b0;
		do_arrive = 1'b0;
		do_launch = 1'b0;
		do_fetch  = 1'b0;
		do_accum  = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			fdrs_pkg::ST_IDLE:   cmd_pop = cmd_valid;
			fdrs_pkg::ST_EXEC:   do_arrive = (cmd_q.kind == fdrs_pkg::CMD_ARRIVE);
			fdrs_pkg::ST_LAUNCH: do_launch = 1'b1;
			fdrs_pkg::ST_FETCH:  do_fetch = 1'b1;
			fdrs_pkg::ST_ACCUM:  do_accum = 1'b1;
			fdrs_pkg::ST_RESULT: out_load = !out_valid_q || res_ready;
			default: ;
		endcase
	end

	// Entry layout: track in the top 16 bits, blocks below it, arrival time low.
	always_ff @(posedge clk) begin
		if (do_arrive && occ_q != LAST_IDX) begin
			mem[head_q] <= {cmd_q.track, cmd_q.blocks, cmd_q.now};
		end
		if (do_launch && nonempty) begin
			rdata_q <= mem[tail_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		if (state_q == fdrs_pkg::ST_EXEC) begin
			start_q <= cmd_q.now + 32'(delay);
		end
		if (do_fetch) begin
			wait_q <= start_q - rdata_q[31:0];
			trk_q  <= rdata_q[63:48];
			blk_q  <= rdata_q[47:32];
		end
		if (out_load) begin
			out_q.dispatched      <= sent_q;
			out_q.start_time      <= sent_q ? start_q : '0;
			out_q.track_out       <= sent_q ? trk_q : '0;
			out_q.blocks_out      <= sent_q ? blk_q : '0;
			out_q.queue_size      <= 10'(occ_q[QW-1:0]);
			out_q.peak_queue_size <= 10'(peak_q[QW-1:0]);
			out_q.total_wait      <= wsum_q;
			out_q.peak_wait       <= wpeak_q;
			out_q.request_count   <= arrivals_q;
			out_q.queue_full      <= full_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fdrs_pkg::ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			occ_q       <= '0;
			peak_q      <= '0;
			busy_q      <= 1'b0;
			wsum_q      <= '0;
			wpeak_q     <= '0;
			arrivals_q  <= '0;
			full_q      <= 1'b0;
			sent_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd_pop) begin
				full_q <= 1'b0;
				sent_q <= 1'b0;
			end
			if (do_arrive) begin
				if (arrivals_q != fdrs_pkg::COUNT_MAX) begin
					arrivals_q <= arrivals_q + 1'b1;
				end
				if (occ_q == LAST_IDX) begin
					full_q <= 1'b1;
				end else begin
					head_q <= (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
					occ_q  <= occ_inc;
					if (occ_inc > peak_q) begin
						peak_q <= occ_inc;
					end
				end
			end
			if (do_launch) begin
				busy_q <= nonempty;
				if (nonempty) begin
					tail_q <= (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
					occ_q  <= occ_q - 1'b1;
					sent_q <= 1'b1;
				end
			end
			if (do_accum) begin
				wsum_q <= sum_ext[48] ? fdrs_pkg::WAIT_SUM_MAX : sum_ext[47:0];
				if (wait_q > wpeak_q) begin
					wpeak_q <= wait_q;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

	logic [AW:0] occ_chk;
	always_comb begin
		if (head_q >= tail_q) begin
			occ_chk = {1'b0, head_q} - {1'b0, tail_q};
		end else begin
			occ_chk = {1'b0, head_q} + (AW+1)'(QUEUE_DEPTH) - {1'b0, tail_q};
		end
	end

	a_occ_matches_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		occ_chk == {1'b0, occ_q})
		else $error("occupancy count disagrees with ring pointers");

	a_peak_covers_occ: assert property (@(posedge clk) disable iff (!arst_n)
		peak_q >= occ_q)
		else $error("peak queue size below current occupancy");

	a_dispatch_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && sent_q) |-> busy_q)
		else $error("dispatch reported while disk idle");

	a_full_no_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fdrs_pkg::ST_RESULT && full_q) |->
		(cmd_q.kind == fdrs_pkg::CMD_ARRIVE && !sent_q))
		else $error("dropped request coincided with a dispatch");

endmodule

@@ src/fifo_disk_request_scheduler.sv @@
// Each accepted input word yields one result word. The back-end sequencer pops a
// command in IDLE and runs EXEC, then RESULT for an arrival while the disk is busy;
// otherwise LAUNCH, plus FETCH and ACCUM when a request is dispatched, then RESULT.
// It runs one command at a time around the single-port request store.
// Reset (arst_n low) clears all control state and statistics and sets dispatch_delay
// to 100; the request store is not cleared and needs no clearing pass.
module fifo_disk_request_scheduler #(
	parameter int QUEUE_DEPTH = fdrs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic [15:0]  cfg_wr_data,   // dispatch_delay
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [63:0]  s_tdata,       // now[31:0], track[47:32], blocks[63:48]
	input  logic         s_tuser,       // op
	output logic         m_tvalid,
	input  logic         m_tready,
	// start_time[31:0], track_out[47:32], blocks_out[63:48], queue_size[73:64],
	// peak_queue_size[83:74], total_wait[131:84], peak_wait[163:132],
	// request_count[195:164], queue_full[196], zero[199:197]
	output logic [199:0] m_tdata,
	output logic         m_tuser        // dispatched
);

	logic [15:0]    delay_q;
	logic           cmd_valid;
	logic           cmd_pop;
	fdrs_pkg::cmd_t cmd;
	fdrs_pkg::res_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= fdrs_pkg::DELAY_RESET;
		end else if (cfg_wr_en) begin
			delay_q <= cfg_wr_data;
		end
	end

	fdrs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	fdrs_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.delay     (delay_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	assign m_tuser = res.dispatched;
	assign m_tdata = {3'b000, res.queue_full, res.request_count, res.peak_wait,
		res.total_wait, res.peak_queue_size, res.queue_size, res.blocks_out,
		res.track_out, res.start_time};

endmodule
